// ----- hdl/ccr_pkg.sv -----
// Shared types and constants for the center-crop RGB565 downscaler.
// Used by every module of the block but ccr_const_div; depends on nothing.
package ccr_pkg;

   localparam int DIM_W = 12;   // frame dimension registers
   localparam int PIX_W = 16;   // RGB565 pixel
   localparam int IDX_W = 14;   // output index
   localparam int CH_W  = 8;    // signed output channel

   localparam int DEF_OUT_WIDTH     = 96;
   localparam int DEF_OUT_HEIGHT    = 96;
   localparam int DEF_MAX_FRAME_DIM = 2048;

   // Register indexes on the CSR port
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Request as it leaves the input register
   typedef struct packed {
      logic             fire;
      logic             frame_start;
      logic [PIX_W-1:0] pixel;
   } req_stage_type;

   // Picked pixel handed to the result register
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] out_index;
      logic [PIX_W-1:0] pixel;
      logic             last;
   } pick_type;

endpackage

// ----- hdl/ccr_in_stage.sv -----
// Input register of the downscaler: holds one request while the result side stalls.
// Depends on ccr_pkg.
module ccr_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [15:0]             req_pixel,
   input  logic                    req_frame_start,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ccr_pkg::req_stage_type  stage
);
   import ccr_pkg::*;

   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] pixel_ff;
   logic             start_ff;
   logic             hold;
   logic             load;

   assign hold      = rsp_valid && rsp_stall;
   assign req_stall = valid_ff && hold;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && hold);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= req_pixel;
         start_ff <= req_frame_start;
      end
   end

   assign stage.fire        = valid_ff && !hold;
   assign stage.frame_start = start_ff;
   assign stage.pixel       = pixel_ff;

endmodule

// ----- hdl/ccr_const_div.sv -----
// Exact floor division of an unsigned value by a constant, by reciprocal multiply.
// Depends on nothing; the shift is wide enough that no correction step is needed.
module ccr_const_div #(
   parameter int DIVISOR = 96,
   parameter int NUM_W   = 19,
   parameter int QUO_W   = 12
) (
   input  logic [NUM_W-1:0] num,
   output logic [QUO_W-1:0] quo
);
   localparam int SHIFT = NUM_W + $clog2(DIVISOR);
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam logic [SHIFT:0] RECIP_M = RECIP[SHIFT:0];

   logic [NUM_W+SHIFT:0] prod;

   assign prod = {{(SHIFT+1){1'b0}}, num} * {{NUM_W{1'b0}}, RECIP_M};
   assign quo  = prod[SHIFT +: QUO_W];

endmodule

// ----- hdl/ccr_core.sv -----
// Crop geometry, raster counters and pixel selection of the downscaler.
// Holds the frame size registers; depends on ccr_pkg and ccr_const_div.
module ccr_core #(
   parameter int OUT_WIDTH     = ccr_pkg::DEF_OUT_WIDTH,
   parameter int OUT_HEIGHT    = ccr_pkg::DEF_OUT_HEIGHT,
   parameter int MAX_FRAME_DIM = ccr_pkg::DEF_MAX_FRAME_DIM
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic                    csr_index,
   input  logic [11:0]             csr_data,
   input  ccr_pkg::req_stage_type  stage,
   output ccr_pkg::pick_type       pick
);
   import ccr_pkg::*;

   localparam int COL_W  = $clog2(OUT_WIDTH + 1);
   localparam int ROW_W  = $clog2(OUT_HEIGHT + 1);
   localparam int PCOL_W = DIM_W + COL_W;
   localparam int PROW_W = DIM_W + ROW_W;

   localparam logic [DIM_W:0]   MAX_DIM  = (DIM_W+1)'(MAX_FRAME_DIM);
   localparam logic [DIM_W-1:0] OW_D     = DIM_W'(OUT_WIDTH);
   localparam logic [DIM_W-1:0] OH_D     = DIM_W'(OUT_HEIGHT);
   localparam logic [COL_W-1:0] OW_C     = COL_W'(OUT_WIDTH);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(OUT_WIDTH - 1);
   localparam logic [ROW_W-1:0] OH_R     = ROW_W'(OUT_HEIGHT);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(OUT_HEIGHT - 1);

   logic [DIM_W-1:0]  fw_ff, fw_in, fh_ff, fh_in;
   logic [DIM_W-1:0]  src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [DIM_W-1:0]  want_col_ff, want_col_in, want_row_ff, want_row_in;
   logic [DIM_W-1:0]  crop_ff, crop_in;
   logic [PCOL_W-1:0] pcol_ff, pcol_in;   // (column + 1) * crop
   logic [PROW_W-1:0] prow_ff, prow_in;   // (row + 1) * crop
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // state as seen after a frame start on this request
   logic [DIM_W-1:0]  src_col_e, src_row_e, want_col_e, want_row_e, crop_e;
   logic [COL_W-1:0]  out_col_e;
   logic [ROW_W-1:0]  out_row_e;
   logic [PCOL_W-1:0] pcol_e;
   logic [PROW_W-1:0] prow_e;
   logic [IDX_W-1:0]  idx_e;

   logic [DIM_W-1:0]  crop_new, x0_new, y0_new, x0_live, y0_live;
   logic [DIM_W-1:0]  qcol, qrow;
   logic [DIM_W:0]    src_col_inc;
   logic [COL_W-1:0]  out_col_inc;
   logic [ROW_W-1:0]  out_row_inc;
   logic              geom_bad, active, match;

   assign crop_new = (fw_ff < fh_ff) ? fw_ff : fh_ff;
   assign x0_new   = (fw_ff - crop_new) >> 1;
   assign y0_new   = (fh_ff - crop_new) >> 1;
   assign geom_bad = (fw_ff == '0) || (fh_ff == '0) ||
                     ({1'b0, fw_ff} > MAX_DIM) || ({1'b0, fh_ff} > MAX_DIM) ||
                     (crop_new < OW_D) || (crop_new < OH_D);

   always_comb begin
      src_col_e  = src_col_ff;
      src_row_e  = src_row_ff;
      out_col_e  = out_col_ff;
      out_row_e  = out_row_ff;
      want_col_e = want_col_ff;
      want_row_e = want_row_ff;
      crop_e     = crop_ff;
      pcol_e     = pcol_ff;
      prow_e     = prow_ff;
      idx_e      = idx_ff;
      if (stage.frame_start) begin
         src_col_e  = '0;
         src_row_e  = '0;
         out_col_e  = '0;
         out_row_e  = '0;
         idx_e      = '0;
         crop_e     = geom_bad ? '0 : crop_new;
         want_col_e = geom_bad ? '0 : x0_new;
         want_row_e = geom_bad ? '0 : y0_new;
         pcol_e     = PCOL_W'(crop_new);
         prow_e     = PROW_W'(crop_new);
      end
   end

   ccr_const_div #(.DIVISOR(OUT_WIDTH), .NUM_W(PCOL_W), .QUO_W(DIM_W)) u_div_col (
      .num (pcol_e),
      .quo (qcol)
   );

   ccr_const_div #(.DIVISOR(OUT_HEIGHT), .NUM_W(PROW_W), .QUO_W(DIM_W)) u_div_row (
      .num (prow_e),
      .quo (qrow)
   );

   // crop offsets follow the live frame size
   assign x0_live = (fw_ff - crop_e) >> 1;
   assign y0_live = (fh_ff - crop_e) >> 1;

   assign active = (fw_ff != '0) && (fh_ff != '0) && (src_row_e < fh_ff);
   assign match  = active && (crop_e != '0) && (fw_ff >= crop_e) && (fh_ff >= crop_e) &&
                   (out_row_e < OH_R) && (src_row_e == want_row_e) &&
                   (src_col_e == want_col_e);

   assign src_col_inc = {1'b0, src_col_e} + (DIM_W+1)'(1);
   assign out_col_inc = out_col_e + COL_W'(1);
   assign out_row_inc = out_row_e + ROW_W'(1);

   always_comb begin
      src_col_in  = src_col_e;
      src_row_in  = src_row_e;
      out_col_in  = out_col_e;
      out_row_in  = out_row_e;
      want_col_in = want_col_e;
      want_row_in = want_row_e;
      crop_in     = crop_e;
      pcol_in     = pcol_e;
      prow_in     = prow_e;
      idx_in      = idx_e;
      if (match) begin
         idx_in = idx_e + IDX_W'(1);
         if (out_col_inc >= OW_C) begin
            out_col_in  = '0;
            out_row_in  = out_row_inc;
            want_col_in = x0_live;
            pcol_in     = PCOL_W'(crop_e);
            if (out_row_inc < OH_R) begin
               want_row_in = y0_live + qrow;
               prow_in     = prow_e + PROW_W'(crop_e);
            end
         end else begin
            out_col_in  = out_col_inc;
            want_col_in = x0_live + qcol;
            pcol_in     = pcol_e + PCOL_W'(crop_e);
         end
      end
      if (active) begin
         if (src_col_inc >= {1'b0, fw_ff}) begin
            src_col_in = '0;
            src_row_in = src_row_e + DIM_W'(1);
         end else begin
            src_col_in = src_col_inc[DIM_W-1:0];
         end
      end
   end

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_in = csr_data;
            CSR_FRAME_HEIGHT: fh_in = csr_data;
            default: begin
               fw_in = fw_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= '0;
         fh_ff       <= '0;
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         want_col_ff <= '0;
         want_row_ff <= '0;
         crop_ff     <= '0;
         pcol_ff     <= '0;
         prow_ff     <= '0;
         idx_ff      <= '0;
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
         if (stage.fire) begin
            src_col_ff  <= src_col_in;
            src_row_ff  <= src_row_in;
            out_col_ff  <= out_col_in;
            out_row_ff  <= out_row_in;
            want_col_ff <= want_col_in;
            want_row_ff <= want_row_in;
            crop_ff     <= crop_in;
            pcol_ff     <= pcol_in;
            prow_ff     <= prow_in;
            idx_ff      <= idx_in;
         end
      end
   end

   assign pick.valid     = stage.fire && match;
   assign pick.out_index = idx_e;
   assign pick.pixel     = stage.pixel;
   assign pick.last      = (out_row_e == LAST_ROW) && (out_col_e == LAST_COL);

endmodule

// ----- hdl/ccr_out_stage.sv -----
// Result register: widens RGB565 channels to signed 8 bits and holds them under stall.
// Depends on ccr_pkg.
module ccr_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  ccr_pkg::pick_type  pick,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_out_index,
   output logic signed [7:0]  rsp_red,
   output logic signed [7:0]  rsp_green,
   output logic signed [7:0]  rsp_blue,
   output logic               rsp_last
);
   import ccr_pkg::*;

   logic                   valid_ff, valid_in;
   logic [IDX_W-1:0]       index_ff;
   logic signed [CH_W-1:0] red_ff, green_ff, blue_ff;
   logic                   last_ff;
   logic [4:0]             r5, b5;
   logic [5:0]             g6;

   assign r5 = pick.pixel[15:11];
   assign g6 = pick.pixel[10:5];
   assign b5 = pick.pixel[4:0];

   assign valid_in = pick.valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // replicate top bits, then flip the sign bit to subtract 128
   always_ff @(posedge clock) begin
      if (pick.valid) begin
         index_ff <= pick.out_index;
         red_ff   <= {~r5[4], r5[3:0], r5[4:2]};
         green_ff <= {~g6[5], g6[4:0], g6[5:4]};
         blue_ff  <= {~b5[4], b5[3:0], b5[4:2]};
         last_ff  <= pick.last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_index = index_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- hdl/center_crop_resize_rgb565_to_s8.sv -----
// Streaming center-crop nearest-neighbor downscaler, RGB565 in, signed 8-bit RGB out.
// Accepts one camera pixel per clock while the result side does not stall; a picked
// pixel reaches the result port through the input register, then the result register.
// Each request is handled in one pass: the next crop position per axis comes from
// one reciprocal multiply by the output size, so the rate is set by that multiply
// path and never by the data. Frame size is written on the CSR port (index 0 width,
// index 1 height) between requests; a frame start latches the crop. No clearing
// pass after reset. Depends on ccr_pkg and the ccr_* modules.
module center_crop_resize_rgb565_to_s8 #(
   parameter int OUT_WIDTH     = ccr_pkg::DEF_OUT_WIDTH,
   parameter int OUT_HEIGHT    = ccr_pkg::DEF_OUT_HEIGHT,
   parameter int MAX_FRAME_DIM = ccr_pkg::DEF_MAX_FRAME_DIM
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [11:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_pixel,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_out_index,
   output logic signed [7:0]  rsp_red,
   output logic signed [7:0]  rsp_green,
   output logic signed [7:0]  rsp_blue,
   output logic               rsp_last
);
   import ccr_pkg::*;

   req_stage_type stage;
   pick_type      pick;

   assign csr_ready = 1'b1;

   ccr_in_stage u_in (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .stage           (stage)
   );

   ccr_core #(
      .OUT_WIDTH     (OUT_WIDTH),
      .OUT_HEIGHT    (OUT_HEIGHT),
      .MAX_FRAME_DIM (MAX_FRAME_DIM)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .stage     (stage),
      .pick      (pick)
   );

   ccr_out_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .pick          (pick),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_index (rsp_out_index),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- bench/center_crop_resize_rgb565_to_s8_test.sv -----
// Self-checking bench for center_crop_resize_rgb565_to_s8: streams camera frames of
// assorted sizes and checks each signed RGB pixel against a crop/resize predictor or a known value.
// Depends on ccr_pkg and the block's RTL only.
module center_crop_resize_rgb565_to_s8_test;
   import ccr_pkg::*;

   localparam int OUT_W       = DEF_OUT_WIDTH;
   localparam int OUT_H       = DEF_OUT_HEIGHT;
   localparam int MAX_DIM     = DEF_MAX_FRAME_DIM;
   localparam int SETTLE      = 8;      // cycles for the two-stage pipe to go quiet
   localparam int LONG_HOLD   = 300;
   localparam int STUCK_LIMIT = 2000;
   localparam int RANDOM_REQS = 600;
   localparam int TAIL_REQS   = 120;
   localparam int MIN_PICKS   = 60;

   typedef struct packed {
      logic [IDX_W-1:0] out_index;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic             last;
   } s8_pixel_type;

   typedef enum logic [2:0] {
      STEP_SET_WIDTH,
      STEP_SET_HEIGHT,
      STEP_SILENT,   // request that must not produce a pixel
      STEP_KNOWN,    // pixel given in the row
      STEP_MODEL     // pixel from the predictor
   } step_kind_type;

   typedef struct packed {
      step_kind_type    kind;
      logic [DIM_W-1:0] dim;
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
      s8_pixel_type     known;
   } step_type;

   localparam s8_pixel_type NO_PIXEL = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = CSR_FRAME_WIDTH;
   logic [DIM_W-1:0]   csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PIX_W-1:0]   req_pixel = '0;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [IDX_W-1:0]   rsp_out_index;
   logic signed [7:0]  rsp_red;
   logic signed [7:0]  rsp_green;
   logic signed [7:0]  rsp_blue;
   logic               rsp_last;

   // predictor state
   int unsigned frame_w = 0;
   int unsigned frame_h = 0;
   int unsigned src_col = 0;
   int unsigned src_row = 0;
   int unsigned out_col = 0;
   int unsigned out_row = 0;
   int unsigned want_col = 0;
   int unsigned want_row = 0;
   int unsigned crop = 0;

   s8_pixel_type picked_q[$];
   step_type     steps[$];
   int           failures = 0;
   int           picks_due = 0;
   int           picks_seen = 0;
   int           hold_at = 0;
   int           burst_left = 0;
   int unsigned  corner_dims[8] = '{0, 1, 95, 96, 97, 2048, 2049, 4095};

   center_crop_resize_rgb565_to_s8 #(
      .OUT_WIDTH(OUT_W),
      .OUT_HEIGHT(OUT_H),
      .MAX_FRAME_DIM(MAX_DIM)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel(req_pixel),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_index(rsp_out_index),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .rsp_last(rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void aim_column();
      want_col = (frame_w - crop) / 2 + out_col * crop / OUT_W;
   endfunction

   function automatic void aim_row();
      want_row = (frame_h - crop) / 2 + out_row * crop / OUT_H;
   endfunction

   // Advance the crop/resize state by one camera pixel; returns 1 when it is picked.
   function automatic bit downscale_pixel(input logic [PIX_W-1:0] pix, input logic start,
                                          output s8_pixel_type px);
      int unsigned side;
      bit          hit;
      px = '0;
      if (start) begin
         side = (frame_w < frame_h) ? frame_w : frame_h;
         src_col = 0;
         src_row = 0;
         out_col = 0;
         out_row = 0;
         if (frame_w == 0 || frame_h == 0 || frame_w > MAX_DIM || frame_h > MAX_DIM ||
             side < OUT_W || side < OUT_H) begin
            crop = 0;
            want_col = 0;
            want_row = 0;
         end else begin
            crop = side;
            aim_column();
            aim_row();
         end
      end
      // drop pixels past the last row or without a frame size
      if (frame_w == 0 || frame_h == 0 || src_row >= frame_h) begin
         return 1'b0;
      end
      hit = crop != 0 && frame_w >= crop && frame_h >= crop && out_row < OUT_H &&
            src_row == want_row && src_col == want_col;
      if (hit) begin
         px.out_index = IDX_W'(out_row * OUT_W + out_col);
         px.red       = {pix[15:11], pix[15:13]} ^ 8'h80;
         px.green     = {pix[10:5], pix[10:9]} ^ 8'h80;
         px.blue      = {pix[4:0], pix[4:2]} ^ 8'h80;
         px.last      = (out_row == OUT_H - 1) && (out_col == OUT_W - 1);
         out_col++;
         if (out_col >= OUT_W) begin
            out_col = 0;
            out_row++;
            if (out_row < OUT_H) begin
               aim_row();
            end
         end
         aim_column();
      end
      src_col++;
      if (src_col >= frame_w) begin
         src_col = 0;
         src_row++;
      end
      return hit;
   endfunction

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("mismatch: %s", what);
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 2);
      end
      if (roll < 95) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         burst_left = $urandom_range(20, 150);
         return 0;
      end
      if (roll < 65) begin
         return 0;
      end
      return pick_gap();
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
         return '0;
      end
      if (roll == 1) begin
         return '1;
      end
      return PIX_W'($urandom);
   endfunction

   // Enter and leave at a falling edge.
   task automatic offer_pixel(input logic [PIX_W-1:0] pix, input logic start,
                              input step_kind_type how, input s8_pixel_type known);
      int           gap;
      bit           hit;
      s8_pixel_type px;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= start;
      do @(posedge clock); while (req_stall !== 1'b0);
      hit = downscale_pixel(pix, start, px);
      if (how == STEP_KNOWN) begin
         picked_q.push_back(known);
      end else if (how == STEP_MODEL && hit) begin
         picked_q.push_back(px);
      end
      if (hit) begin
         picks_due++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (picked_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_FRAME_WIDTH) begin
         frame_w = val;
      end else begin
         frame_h = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      step_type    st;
      int unsigned w;
      int unsigned h;
      int unsigned side;
      int          roll;
      int          n;
      int          random_reqs;
      bit          fresh;

      // no frame start since reset, then frames with missing or bad sizes
      steps.push_back('{STEP_SILENT, 12'd0, 16'hABCD, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_SILENT, 12'd0, 16'hFFFF, 1'b1, NO_PIXEL});
      steps.push_back('{STEP_SET_WIDTH, 12'd96, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_SILENT, 12'd0, 16'h0000, 1'b1, NO_PIXEL});
      steps.push_back('{STEP_SET_HEIGHT, 12'd4095, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_SILENT, 12'd0, 16'h1234, 1'b1, NO_PIXEL});
      steps.push_back('{STEP_SET_HEIGHT, 12'd95, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_SILENT, 12'd0, 16'h4321, 1'b1, NO_PIXEL});
      // exact fit: every pixel of the first row is picked
      steps.push_back('{STEP_SET_HEIGHT, 12'd96, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_KNOWN, 12'd0, 16'hFFFF, 1'b1,
                        '{14'd0, 8'h7F, 8'h7F, 8'h7F, 1'b0}});
      steps.push_back('{STEP_KNOWN, 12'd0, 16'h0000, 1'b0,
                        '{14'd1, 8'h80, 8'h80, 8'h80, 1'b0}});
      steps.push_back('{STEP_KNOWN, 12'd0, 16'hF800, 1'b0,
                        '{14'd2, 8'h7F, 8'h80, 8'h80, 1'b0}});
      steps.push_back('{STEP_KNOWN, 12'd0, 16'h07E0, 1'b0,
                        '{14'd3, 8'h80, 8'h7F, 8'h80, 1'b0}});
      steps.push_back('{STEP_KNOWN, 12'd0, 16'h001F, 1'b0,
                        '{14'd4, 8'h80, 8'h80, 8'h7F, 1'b0}});
      steps.push_back('{STEP_MODEL, 12'd0, 16'h8410, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_MODEL, 12'd0, 16'h5555, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_MODEL, 12'd0, 16'hAAAA, 1'b0, NO_PIXEL});
      // largest frame: sparse picks
      steps.push_back('{STEP_SET_WIDTH, 12'd2048, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_SET_HEIGHT, 12'd2048, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_MODEL, 12'd0, 16'h7BEF, 1'b1, NO_PIXEL});
      steps.push_back('{STEP_MODEL, 12'd0, 16'h8410, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_MODEL, 12'd0, 16'hC3A5, 1'b0, NO_PIXEL});
      // off-center crop: column 0 lies outside it
      steps.push_back('{STEP_SET_WIDTH, 12'd100, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_SET_HEIGHT, 12'd97, 16'h0000, 1'b0, NO_PIXEL});
      steps.push_back('{STEP_SILENT, 12'd0, 16'h3C3C, 1'b1, NO_PIXEL});
      steps.push_back('{STEP_KNOWN, 12'd0, 16'hFFFF, 1'b0,
                        '{14'd0, 8'h7F, 8'h7F, 8'h7F, 1'b0}});
      steps.push_back('{STEP_MODEL, 12'd0, 16'h0F0F, 1'b0, NO_PIXEL});

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         st = steps[i];
         case (st.kind)
            STEP_SET_WIDTH:  write_reg(CSR_FRAME_WIDTH, st.dim);
            STEP_SET_HEIGHT: write_reg(CSR_FRAME_HEIGHT, st.dim);
            default:         offer_pixel(st.pixel, st.frame_start, st.kind, st.known);
         endcase
      end

      random_reqs = 0;
      while (random_reqs < RANDOM_REQS || picks_due < MIN_PICKS) begin
         roll = $urandom_range(0, 99);
         fresh = 1'b1;
         if (roll < 65) begin
            // crop near the output size with the first picked row close to the top
            side = $urandom_range(96, 120);
            w = side + $urandom_range(0, 30);
            h = side + $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) begin
               {w, h} = {h, w};
            end
         end else if (roll < 75) begin
            w = $urandom_range(0, 130);
            h = $urandom_range(90, 100);
         end else if (roll < 83) begin
            w = corner_dims[$urandom_range(0, 7)];
            h = corner_dims[$urandom_range(0, 7)];
         end else if (roll < 90) begin
            w = $urandom_range(0, 4095);
            h = $urandom_range(0, 4095);
         end else begin
            // resize the frame under way, without a new frame start
            fresh = 1'b0;
            w = $urandom_range(0, 1) ? frame_w : $urandom_range(90, 140);
            h = $urandom_range(1, 130);
         end
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_FRAME_WIDTH, DIM_W'(w));
            write_reg(CSR_FRAME_HEIGHT, DIM_W'(h));
         end else begin
            write_reg(CSR_FRAME_HEIGHT, DIM_W'(h));
            write_reg(CSR_FRAME_WIDTH, DIM_W'(w));
         end
         n = $urandom_range(20, 220);
         for (int i = 0; i < n; i++) begin
            offer_pixel(random_pixel(), (i == 0) ? fresh : ($urandom_range(0, 199) == 0),
                        STEP_MODEL, NO_PIXEL);
            random_reqs++;
         end
      end

      // exact fit again: every pixel of the first row is picked, so a long hold
      // on the result side backs the block up into its input
      write_reg(CSR_FRAME_WIDTH, DIM_W'(OUT_W));
      write_reg(CSR_FRAME_HEIGHT, DIM_W'(OUT_H));
      hold_at = picks_seen + 20;
      for (int i = 0; i < TAIL_REQS; i++) begin
         offer_pixel(random_pixel(), i == 0, STEP_MODEL, NO_PIXEL);
      end

      wait_drained();
      if (failures == 0) begin
         $display("center_crop_resize_rgb565_to_s8_test: PASS");
      end else begin
         $display("center_crop_resize_rgb565_to_s8_test: FAIL");
      end
      $finish;
   end

   initial begin : result_side
      s8_pixel_type want;
      int           stall_left;
      int           calm_left;
      int           roll;
      bit           held_long;
      stall_left = 0;
      calm_left  = 0;
      held_long  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            picks_seen++;
            if (picked_q.size() == 0) begin
               note_failure($sformatf("pixel at index %0d with no request behind it",
                                      rsp_out_index));
            end else begin
               want = picked_q.pop_front();
               if (rsp_out_index !== want.out_index || rsp_red !== want.red ||
                   rsp_green !== want.green || rsp_blue !== want.blue ||
                   rsp_last !== want.last) begin
                  note_failure($sformatf(
                     "index %0d/%0d red %0d/%0d green %0d/%0d blue %0d/%0d last %0b/%0b",
                     want.out_index, rsp_out_index, $signed(want.red), rsp_red,
                     $signed(want.green), rsp_green, $signed(want.blue), rsp_blue,
                     want.last, rsp_last));
               end
            end
         end
         @(negedge clock);
         // hold off once mid-frame so the block backs up into its input
         if (!held_long && hold_at != 0 && picks_seen >= hold_at) begin
            held_long  = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (calm_left > 0) begin
            rsp_stall <= 1'b0;
            calm_left--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               calm_left = $urandom_range(20, 120);
               rsp_stall <= 1'b0;
            end else if (roll < 25) begin
               stall_left = pick_gap() - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("center_crop_resize_rgb565_to_s8_test: FAIL");
      $finish;
   end

endmodule
